[hw/rtl/dvr_pkg.sv]
// ----------------------------------------------------------------------------
// dvr_pkg
// Shared types and codes for the distance-vector route update unit: route
// actions, request kinds, the query records given to every cell of a chain,
// and the token records that travel along the cell chains.
// ----------------------------------------------------------------------------
package dvr_pkg;

    localparam int ID_W  = 16;
    localparam int HOP_W = 8;

    localparam logic [HOP_W-1:0] HOP_MAX = 8'd255;
    localparam logic [HOP_W-1:0] HOP_ONE = 8'd1;

    // request kinds carried in s_tuser
    localparam logic [1:0] REQ_HEADER = 2'd0;
    localparam logic [1:0] REQ_ENTRY  = 2'd1;
    localparam logic [1:0] REQ_HELLO  = 2'd2;

    // route actions
    localparam logic [2:0] ACT_NONE     = 3'd0;
    localparam logic [2:0] ACT_INSERTED = 3'd1;
    localparam logic [2:0] ACT_IMPROVED = 3'd2;
    localparam logic [2:0] ACT_KEPT     = 3'd3;
    localparam logic [2:0] ACT_DROPPED  = 3'd4;

    // held steady for the whole walk of one item along the route chain
    typedef struct packed {
        logic [ID_W-1:0]  key;
        logic [ID_W-1:0]  next_hop;
        logic [HOP_W-1:0] new_hops;
        logic [HOP_W-1:0] cmp_hops;
        logic             improve_en;
    } route_query_t;

    typedef struct packed {
        logic             active;
        logic             found;
        logic [2:0]       action;
        logic [HOP_W-1:0] hops;
    } route_token_t;

    typedef struct packed {
        logic [ID_W-1:0]  key;
        logic [ID_W-1:0]  next_hop;
        logic [HOP_W-1:0] hops;
    } direct_query_t;

    typedef struct packed {
        logic active;
        logic found;
        logic added;
    } direct_token_t;

endpackage

[hw/rtl/dvr_route_cell.sv]
// ----------------------------------------------------------------------------
// dvr_route_cell
// One route list entry. A search token is registered as it passes through;
// the first match updates itself if improved, the first empty cell inserts.
// ----------------------------------------------------------------------------
module dvr_route_cell (
    input  logic                  clk,
    input  logic                  rst_n,
    input  dvr_pkg::route_query_t query,
    input  dvr_pkg::route_token_t tok_in,
    output dvr_pkg::route_token_t tok_out
);

    logic                       valid_reg;
    logic                       valid_next;
    logic [dvr_pkg::ID_W-1:0]   source_reg;
    logic [dvr_pkg::ID_W-1:0]   next_hop_reg;
    logic [dvr_pkg::HOP_W-1:0]  hops_reg;
    dvr_pkg::route_token_t      tok_reg;
    dvr_pkg::route_token_t      tok_next;
    logic                       write_en;
    logic                       hit;

    assign hit = valid_reg && (source_reg == query.key);

    always_comb
    begin
        tok_next   = tok_in;
        write_en   = 1'b0;
        valid_next = valid_reg;
        if (tok_in.active && !tok_in.found)
        begin
            if (hit)
            begin
                tok_next.found = 1'b1;
                if (query.improve_en && (hops_reg > query.cmp_hops))
                begin
                    write_en        = 1'b1;
                    tok_next.action = dvr_pkg::ACT_IMPROVED;
                    tok_next.hops   = query.new_hops;
                end
                else
                begin
                    tok_next.action = dvr_pkg::ACT_KEPT;
                    tok_next.hops   = hops_reg;
                end
            end
            else if (!valid_reg)
            begin
                // valid cells are contiguous, so this is the append slot
                write_en        = 1'b1;
                valid_next      = 1'b1;
                tok_next.found  = 1'b1;
                tok_next.action = dvr_pkg::ACT_INSERTED;
                tok_next.hops   = query.new_hops;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            tok_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            tok_reg   <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (write_en)
        begin
            source_reg   <= query.key;
            next_hop_reg <= query.next_hop;
            hops_reg     <= query.new_hops;
        end
    end

    assign tok_out = tok_reg;

endmodule

[hw/rtl/dvr_direct_cell.sv]
// ----------------------------------------------------------------------------
// dvr_direct_cell
// One direct-route table entry keyed by sender. A token carries the lookup
// through; the first empty cell takes the insert if no cell matched.
// ----------------------------------------------------------------------------
module dvr_direct_cell (
    input  logic                   clk,
    input  logic                   rst_n,
    input  dvr_pkg::direct_query_t query,
    input  dvr_pkg::direct_token_t tok_in,
    output dvr_pkg::direct_token_t tok_out
);

    logic                       valid_reg;
    logic                       valid_next;
    logic [dvr_pkg::ID_W-1:0]   key_reg;
    logic [dvr_pkg::ID_W-1:0]   next_hop_reg;
    logic [dvr_pkg::HOP_W-1:0]  hops_reg;
    dvr_pkg::direct_token_t     tok_reg;
    dvr_pkg::direct_token_t     tok_next;
    logic                       write_en;

    always_comb
    begin
        tok_next   = tok_in;
        write_en   = 1'b0;
        valid_next = valid_reg;
        if (tok_in.active && !tok_in.found)
        begin
            if (valid_reg && (key_reg == query.key))
            begin
                tok_next.found = 1'b1;
            end
            else if (!valid_reg)
            begin
                write_en       = 1'b1;
                valid_next     = 1'b1;
                tok_next.found = 1'b1;
                tok_next.added = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            tok_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            tok_reg   <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (write_en)
        begin
            key_reg      <= query.key;
            next_hop_reg <= query.next_hop;
            hops_reg     <= query.hops;
        end
    end

    assign tok_out = tok_reg;

endmodule

[hw/rtl/distance_vector_route_update_unit.sv]
// ----------------------------------------------------------------------------
// distance_vector_route_update_unit
// Route list and direct-route table update for a distance-vector router.
// ----------------------------------------------------------------------------
// Items enter on the s_ group: s_tuser holds the request kind (header,
// vector entry, hello), s_tdata the sender, ttl and vector entry. One
// result item per input item leaves on the m_ group. The user must write own_node_id
// via cfg_we / cfg_wdata only while the block is idle; the block does not enforce it.
// Each route entry lives in one cell of a chain; a search token walks the
// chain one cell per cycle, and the first matching cell (or the first empty
// one) applies the update. A second chain holds the direct-route table.
// A header or vector entry item is finished once its search token has
// walked the whole route chain; an entry naming own_node_id also walks
// the direct chain, and its result waits for both walks. Hello and unused
// kinds skip the chains.
// One item is worked on at a time; s_tready is high once the previous
// result has moved into the output register.
// Reset empties both tables and clears the recorded sender and own_node_id.
// A finished result sits in the output register while m_tready is low; the
// next item is accepted meanwhile, and its result waits until the output
// register is free.
// ----------------------------------------------------------------------------
module distance_vector_route_update_unit #(
    parameter int ROUTE_ENTRIES  = 32,
    parameter int DIRECT_ENTRIES = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,      // own_node_id
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,        // sender, ttl, entry source, entry next hop,
                                        // entry hops
    input  logic [1:0]  s_tuser,        // req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata         // route_action, forward_frame, direct_route_added,
                                        // stored_hops, zero fill
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic                      state_reg;
    logic                      state_next;
    logic [dvr_pkg::ID_W-1:0]  own_id_reg;
    logic [dvr_pkg::ID_W-1:0]  own_id_next;
    logic [dvr_pkg::ID_W-1:0]  cur_sender_reg;
    logic [dvr_pkg::ID_W-1:0]  cur_sender_next;

    dvr_pkg::route_query_t     rq_reg;
    dvr_pkg::route_query_t     rq_next;
    dvr_pkg::direct_query_t    dq_reg;
    dvr_pkg::direct_query_t    dq_next;
    dvr_pkg::route_token_t     rt_launch_reg;
    dvr_pkg::route_token_t     rt_launch_next;
    dvr_pkg::direct_token_t    dt_launch_reg;
    dvr_pkg::direct_token_t    dt_launch_next;

    logic [2:0]                pend_action_reg;
    logic [2:0]                pend_action_next;
    logic                      pend_fwd_reg;
    logic                      pend_fwd_next;
    logic                      pend_direct_reg;
    logic                      pend_direct_next;
    logic [dvr_pkg::HOP_W-1:0] pend_hops_reg;
    logic [dvr_pkg::HOP_W-1:0] pend_hops_next;
    logic                      route_done_reg;
    logic                      route_done_next;
    logic                      direct_done_reg;
    logic                      direct_done_next;

    logic                      m_tvalid_reg;
    logic                      m_tvalid_next;
    logic [15:0]               out_data_reg;
    logic [15:0]               out_data_next;

    logic                      accept;
    logic                      load_out;
    logic [1:0]                in_type;
    logic [dvr_pkg::ID_W-1:0]  in_sender;
    logic [dvr_pkg::HOP_W-1:0] in_ttl;
    logic [dvr_pkg::ID_W-1:0]  in_esrc;
    logic [dvr_pkg::ID_W-1:0]  in_efirst;
    logic [dvr_pkg::HOP_W-1:0] in_ehops;
    logic [dvr_pkg::HOP_W-1:0] sat_hops;
    logic                      ttl_fwd;

    dvr_pkg::route_token_t     rt_chain [0:ROUTE_ENTRIES];
    dvr_pkg::direct_token_t    dt_chain [0:DIRECT_ENTRIES];
    logic [ROUTE_ENTRIES:0]    rt_active;
    dvr_pkg::route_token_t     rt_end;
    dvr_pkg::direct_token_t    dt_end;

    assign in_type   = s_tuser;
    assign in_sender = s_tdata[15:0];
    assign in_ttl    = s_tdata[23:16];
    assign in_esrc   = s_tdata[39:24];
    assign in_efirst = s_tdata[55:40];
    assign in_ehops  = s_tdata[63:56];

    assign sat_hops = (in_ehops == dvr_pkg::HOP_MAX) ? dvr_pkg::HOP_MAX
                                                     : in_ehops + dvr_pkg::HOP_ONE;
    assign ttl_fwd  = (in_ttl > dvr_pkg::HOP_ONE);

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign load_out = (state_reg == ST_RUN) && route_done_reg && direct_done_reg &&
                      (!m_tvalid_reg || m_tready);

    // cell chains
    assign rt_chain[0] = rt_launch_reg;
    assign dt_chain[0] = dt_launch_reg;
    assign rt_end      = rt_chain[ROUTE_ENTRIES];
    assign dt_end      = dt_chain[DIRECT_ENTRIES];

    genvar gi;
    generate
        for (gi = 0; gi < ROUTE_ENTRIES; gi++)
        begin : g_route
            dvr_route_cell u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .query   (rq_reg),
                .tok_in  (rt_chain[gi]),
                .tok_out (rt_chain[gi+1])
            );
        end
        for (gi = 0; gi <= ROUTE_ENTRIES; gi++)
        begin : g_active
            assign rt_active[gi] = rt_chain[gi].active;
        end
        for (gi = 0; gi < DIRECT_ENTRIES; gi++)
        begin : g_direct
            dvr_direct_cell u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .query   (dq_reg),
                .tok_in  (dt_chain[gi]),
                .tok_out (dt_chain[gi+1])
            );
        end
    endgenerate

    assign own_id_next = cfg_we ? cfg_wdata : own_id_reg;

    always_comb
    begin
        state_next       = state_reg;
        cur_sender_next  = cur_sender_reg;
        rq_next          = rq_reg;
        dq_next          = dq_reg;
        rt_launch_next   = '0;
        dt_launch_next   = '0;
        pend_action_next = pend_action_reg;
        pend_fwd_next    = pend_fwd_reg;
        pend_direct_next = pend_direct_reg;
        pend_hops_next   = pend_hops_reg;
        route_done_next  = route_done_reg;
        direct_done_next = direct_done_reg;

        if (accept)
        begin
            state_next       = ST_RUN;
            pend_action_next = dvr_pkg::ACT_NONE;
            pend_fwd_next    = 1'b0;
            pend_direct_next = 1'b0;
            pend_hops_next   = '0;
            route_done_next  = 1'b1;
            direct_done_next = 1'b1;
            case (in_type)
                dvr_pkg::REQ_HEADER:
                begin
                    cur_sender_next       = in_sender;
                    rq_next.key           = in_sender;
                    rq_next.next_hop      = own_id_reg;
                    rq_next.new_hops      = dvr_pkg::HOP_ONE;
                    rq_next.cmp_hops      = '0;
                    rq_next.improve_en    = 1'b0;
                    rt_launch_next.active = 1'b1;
                    route_done_next       = 1'b0;
                    pend_fwd_next         = ttl_fwd;
                end
                dvr_pkg::REQ_ENTRY:
                begin
                    rq_next.key           = in_esrc;
                    rq_next.next_hop      = in_efirst;
                    rq_next.new_hops      = sat_hops;
                    rq_next.cmp_hops      = in_ehops;
                    rq_next.improve_en    = 1'b1;
                    rt_launch_next.active = 1'b1;
                    route_done_next       = 1'b0;
                    dq_next.key           = cur_sender_reg;
                    dq_next.next_hop      = in_efirst;
                    dq_next.hops          = in_ehops;
                    if (in_esrc == own_id_reg)
                    begin
                        dt_launch_next.active = 1'b1;
                        direct_done_next      = 1'b0;
                    end
                end
                dvr_pkg::REQ_HELLO:
                begin
                    pend_fwd_next = ttl_fwd;
                end
                default:
                begin
                    pend_fwd_next = 1'b0;
                end
            endcase
        end
        else if (state_reg == ST_RUN)
        begin
            if (rt_end.active)
            begin
                // a token that met no match and no free cell means a full list
                pend_action_next = rt_end.found ? rt_end.action : dvr_pkg::ACT_DROPPED;
                pend_hops_next   = rt_end.found ? rt_end.hops : '0;
                route_done_next  = 1'b1;
            end
            if (dt_end.active)
            begin
                pend_direct_next = dt_end.added;
                direct_done_next = 1'b1;
            end
            if (load_out)
            begin
                state_next = ST_IDLE;
            end
        end
    end

    assign out_data_next = load_out ? {3'b000, pend_hops_reg, pend_direct_reg,
                                       pend_fwd_reg, pend_action_reg}
                                    : out_data_reg;
    assign m_tvalid_next = load_out ? 1'b1 : (m_tvalid_reg && !m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            own_id_reg      <= '0;
            cur_sender_reg  <= '0;
            rt_launch_reg   <= '0;
            dt_launch_reg   <= '0;
            route_done_reg  <= 1'b1;
            direct_done_reg <= 1'b1;
            m_tvalid_reg    <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            own_id_reg      <= own_id_next;
            cur_sender_reg  <= cur_sender_next;
            rt_launch_reg   <= rt_launch_next;
            dt_launch_reg   <= dt_launch_next;
            route_done_reg  <= route_done_next;
            direct_done_reg <= direct_done_next;
            m_tvalid_reg    <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rq_reg          <= rq_next;
        dq_reg          <= dq_next;
        pend_action_reg <= pend_action_next;
        pend_fwd_reg    <= pend_fwd_next;
        pend_direct_reg <= pend_direct_next;
        pend_hops_reg   <= pend_hops_next;
        out_data_reg    <= out_data_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_data_reg;

    // only one search token is ever on the route chain
    a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(rt_active))
        else $error("more than one route token in flight");

    // a token only leaves the chain while an item is being worked on
    a_end_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        (rt_end.active || dt_end.active) |-> (state_reg == ST_RUN))
        else $error("chain token ended outside a run");

    // dropped routes report no hop count
    a_drop_hops: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tdata[2:0] == dvr_pkg::ACT_DROPPED)) |-> (m_tdata[12:5] == '0))
        else $error("dropped route with non-zero hops");

    // a direct route only comes with a vector entry, which always has an action
    a_direct_action: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[4]) |-> (m_tdata[2:0] != dvr_pkg::ACT_NONE))
        else $error("direct route reported without route action");

    // no new item is taken while a result is still pending inside
    a_no_accept_run: assert property (@(posedge clk) disable iff (!rst_n)
        (!route_done_reg || !direct_done_reg) |-> !s_tready)
        else $error("ready while a walk is in progress");

endmodule
